### rtl/lacg_pkg.sv
package lacg_pkg;

    localparam int DEF_HISTORY_DEPTH = 8;
    localparam int DEF_NUM_CORES     = 4;

    localparam int LOAD_UNIT         = 100;
    localparam int ALL_LOAD_PER_CORE = 120;
    localparam int DEFAULT_INTERVAL  = 20;
    localparam int LOAD_MAX          = 102300;

    localparam int FUNC_W   = 2;
    localparam int RUN_W    = 10;
    localparam int CORE_W   = 4;
    localparam int ACTION_W = 3;
    localparam int DELAY_W  = 23;
    localparam int AVG_W    = 17;
    localparam int IVL_W    = 16;
    localparam int SCALE_W  = 4;
    localparam int THR_W    = 10;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [DELAY_W-1:0] DELAY_MAX = {DELAY_W{1'b1}};

    typedef enum logic [FUNC_W-1:0] {
        FUNC_SAMPLE  = 2'd0,
        FUNC_BOOST   = 2'd1,
        FUNC_UNPAUSE = 2'd2
    } func_t;

    typedef enum logic [ACTION_W-1:0] {
        ACT_NONE     = 3'd0,
        ACT_ALL      = 3'd1,
        ACT_ONE      = 3'd2,
        ACT_OFF      = 3'd3,
        ACT_RESAMPLE = 3'd4
    } action_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ENABLE    = 3'd0,
        REG_MIN_CORES = 3'd1,
        REG_MAX_CORES = 3'd2,
        REG_INTERVAL  = 3'd3,
        REG_SCALE     = 3'd4,
        REG_RAISE     = 3'd5,
        REG_LOWER     = 3'd6
    } cfg_reg_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_UPDATE,
        ST_MULT,
        ST_SCALE,
        ST_DECIDE,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic capture;
        logic read;
        logic update;
        logic mult;
        logic scale;
        logic decide;
    } lacg_cmd_t;

    typedef struct packed {
        logic is_sample;
    } lacg_status_t;

endpackage

### rtl/lacg_if.sv
interface lacg_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] func;
    logic [9:0] run_count;
    logic [3:0] cores_online;
    logic       offline_pending;
    logic       screen_suspended;

    modport source (output valid, func, run_count, cores_online, offline_pending,
                    screen_suspended, input ready);
    modport sink (input valid, func, run_count, cores_online, offline_pending,
                  screen_suspended, output ready);
endinterface

interface lacg_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  action;
    logic        cancel_offline;
    logic        start_unpause_timer;
    logic [22:0] next_delay;
    logic [16:0] average_load;
    logic        paused_now;
    logic        boost_now;

    modport source (output valid, action, cancel_offline, start_unpause_timer, next_delay,
                    average_load, paused_now, boost_now, input ready);
    modport sink (input valid, action, cancel_offline, start_unpause_timer, next_delay,
                  average_load, paused_now, boost_now, output ready);
endinterface

interface lacg_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [15:0] data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

### rtl/lacg_ctrl.sv
module lacg_ctrl (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    evt_valid,
    output logic                    evt_ready,
    output logic                    res_valid,
    input  logic                    res_ready,
    input  lacg_pkg::lacg_status_t  status,
    output lacg_pkg::lacg_cmd_t     cmd
);
    import lacg_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (evt_valid)
                begin
                    state_next = ST_READ;
                end
            end
            ST_READ:
            begin
                state_next = status.is_sample ? ST_UPDATE : ST_MULT;
            end
            ST_UPDATE: state_next = ST_MULT;
            ST_MULT:   state_next = ST_SCALE;
            ST_SCALE:  state_next = ST_DECIDE;
            ST_DECIDE: state_next = ST_OUT;
            ST_OUT:
            begin
                if (res_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:   state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd         = '0;
        evt_ready   = 1'b0;
        res_valid   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                evt_ready   = 1'b1;
                cmd.capture = evt_valid;
            end
            ST_READ:   cmd.read   = 1'b1;
            ST_UPDATE: cmd.update = 1'b1;
            ST_MULT:   cmd.mult   = 1'b1;
            ST_SCALE:  cmd.scale  = 1'b1;
            ST_DECIDE: cmd.decide = 1'b1;
            ST_OUT:    res_valid  = 1'b1;
            default:   cmd        = '0;
        endcase
    end

endmodule

### rtl/lacg_dp.sv
module lacg_dp #(
    parameter int HISTORY_DEPTH = lacg_pkg::DEF_HISTORY_DEPTH,
    parameter int NUM_CORES     = lacg_pkg::DEF_NUM_CORES
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  lacg_pkg::lacg_cmd_t                  cmd,
    output lacg_pkg::lacg_status_t               status,
    input  logic [lacg_pkg::FUNC_W-1:0]          func,
    input  logic [lacg_pkg::RUN_W-1:0]           run_count,
    input  logic [lacg_pkg::CORE_W-1:0]          cores_online,
    input  logic                                 offline_pending,
    input  logic                                 screen_suspended,
    input  logic                                 cfg_write,
    input  logic [lacg_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [lacg_pkg::CFG_DATA_W-1:0]      cfg_data,
    output logic [lacg_pkg::ACTION_W-1:0]        action,
    output logic                                 cancel_offline,
    output logic                                 start_unpause_timer,
    output logic [lacg_pkg::DELAY_W-1:0]         next_delay,
    output logic [lacg_pkg::AVG_W-1:0]           average_load,
    output logic                                 paused_now,
    output logic                                 boost_now
);
    import lacg_pkg::*;

    localparam int POS_W   = $clog2(HISTORY_DEPTH);
    localparam int SUM_W   = $clog2(LOAD_MAX * HISTORY_DEPTH + 1);
    localparam int SHIFT   = SUM_W + $clog2(HISTORY_DEPTH);
    localparam int RECIP_W = SUM_W + 1;
    localparam int PROD_W  = SUM_W + RECIP_W;
    localparam longint unsigned RECIP =
        ((64'd1 << SHIFT) + longint'(HISTORY_DEPTH) - 1) / longint'(HISTORY_DEPTH);
    localparam int CTHR_W  = THR_W + CORE_W;
    localparam int D1_W    = IVL_W + CORE_W;
    localparam int D2_W    = D1_W + SCALE_W;
    localparam logic [AVG_W-1:0] ALL_THR = AVG_W'(ALL_LOAD_PER_CORE * NUM_CORES);

    // configuration
    logic               enable_reg;
    logic [CORE_W-1:0]  min_cores_reg;
    logic [CORE_W-1:0]  max_cores_reg;
    logic [IVL_W-1:0]   interval_reg;
    logic [SCALE_W-1:0] scale_reg;
    logic [THR_W-1:0]   raise_reg;
    logic [THR_W-1:0]   lower_reg;

    // state
    logic [AVG_W-1:0]          ring_mem [HISTORY_DEPTH];
    logic [HISTORY_DEPTH-1:0]  ring_vld_reg;
    logic [POS_W-1:0]          pos_reg;
    logic [SUM_W-1:0]          sum_reg;
    logic [SUM_W-1:0]          sum_next;
    logic                      paused_reg;
    logic                      boost_reg;
    logic                      paused_next;
    logic                      boost_next;

    // captured event and intermediates
    logic [FUNC_W-1:0]  func_reg;
    logic [RUN_W-1:0]   run_reg;
    logic [CORE_W-1:0]  cores_reg;
    logic               pending_reg;
    logic               susp_reg;
    logic [AVG_W-1:0]   sample_reg;
    logic [AVG_W-1:0]   rd_mem_reg;
    logic               rd_vld_reg;
    logic [PROD_W-1:0]  avg_prod_reg;
    logic [CTHR_W-1:0]  raise_prod_reg;
    logic [CTHR_W-1:0]  lower_prod_reg;
    logic [D1_W-1:0]    dly1_reg;
    logic [D2_W-1:0]    dly2_reg;

    logic [ACTION_W-1:0] action_reg;
    logic                cancel_reg;
    logic                timer_reg;
    logic [DELAY_W-1:0]  delay_reg;

    logic [ACTION_W-1:0] action_next;
    logic                cancel_next;
    logic                timer_next;
    logic [DELAY_W-1:0]  delay_next;

    logic [IVL_W-1:0]   eff_ivl;
    logic [CORE_W-1:0]  lo;
    logic [CORE_W-1:0]  hi;
    logic [SCALE_W-1:0] mul_sel;
    logic [AVG_W-1:0]   avg;
    logic [DELAY_W-1:0] dly_sat;
    logic [AVG_W-1:0]   old_entry;

    assign eff_ivl   = (interval_reg == '0) ? IVL_W'(DEFAULT_INTERVAL) : interval_reg;
    assign lo        = (min_cores_reg == '0) ? CORE_W'(1) : min_cores_reg;
    assign hi        = (max_cores_reg > CORE_W'(NUM_CORES)) ? CORE_W'(NUM_CORES) : max_cores_reg;
    assign mul_sel   = (scale_reg == '0) ? SCALE_W'(cores_reg) : scale_reg;
    assign avg       = avg_prod_reg[SHIFT +: AVG_W];
    assign dly_sat   = (dly2_reg > D2_W'(DELAY_MAX)) ? DELAY_MAX : dly2_reg[DELAY_W-1:0];
    assign old_entry = rd_vld_reg ? rd_mem_reg : '0;
    assign sum_next  = sum_reg - SUM_W'(old_entry) + SUM_W'(sample_reg);

    assign status.is_sample = (func_reg == FUNC_SAMPLE) && enable_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_reg    <= 1'b0;
            min_cores_reg <= CORE_W'(2);
            max_cores_reg <= CORE_W'(4);
            interval_reg  <= IVL_W'(20);
            scale_reg     <= SCALE_W'(2);
            raise_reg     <= THR_W'(200);
            lower_reg     <= THR_W'(50);
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_ENABLE:    enable_reg    <= cfg_data[0];
                REG_MIN_CORES: min_cores_reg <= cfg_data[CORE_W-1:0];
                REG_MAX_CORES: max_cores_reg <= cfg_data[CORE_W-1:0];
                REG_INTERVAL:  interval_reg  <= cfg_data[IVL_W-1:0];
                REG_SCALE:     scale_reg     <= cfg_data[SCALE_W-1:0];
                REG_RAISE:     raise_reg     <= cfg_data[THR_W-1:0];
                REG_LOWER:     lower_reg     <= cfg_data[THR_W-1:0];
                default:       enable_reg    <= enable_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ring_vld_reg <= '0;
            pos_reg      <= '0;
            sum_reg      <= '0;
            paused_reg   <= 1'b1;
            boost_reg    <= 1'b0;
        end
        else
        begin
            if (cmd.update)
            begin
                ring_vld_reg[pos_reg] <= 1'b1;
                sum_reg               <= sum_next;
                pos_reg               <= (pos_reg == POS_W'(HISTORY_DEPTH - 1)) ?
                                         '0 : pos_reg + POS_W'(1);
            end
            if (cmd.decide)
            begin
                paused_reg <= paused_next;
                boost_reg  <= boost_next;
            end
        end
    end

    // ring memory: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (cmd.update)
        begin
            ring_mem[pos_reg] <= sample_reg;
        end
        if (cmd.read)
        begin
            rd_mem_reg <= ring_mem[pos_reg];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            func_reg    <= func;
            run_reg     <= run_count;
            cores_reg   <= (cores_online == '0) ? CORE_W'(1) : cores_online;
            pending_reg <= offline_pending;
            susp_reg    <= screen_suspended;
        end
        if (cmd.read)
        begin
            rd_vld_reg <= ring_vld_reg[pos_reg];
            sample_reg <= AVG_W'(run_reg) * AVG_W'(LOAD_UNIT);
        end
        if (cmd.mult)
        begin
            avg_prod_reg   <= PROD_W'(sum_reg) * PROD_W'(RECIP);
            raise_prod_reg <= CTHR_W'(raise_reg) * CTHR_W'(cores_reg);
            lower_prod_reg <= CTHR_W'(lower_reg) * CTHR_W'(cores_reg);
            dly1_reg       <= D1_W'(eff_ivl) * D1_W'(cores_reg);
        end
        if (cmd.scale)
        begin
            dly2_reg <= D2_W'(dly1_reg) * D2_W'(mul_sel);
        end
        if (cmd.decide)
        begin
            action_reg <= action_next;
            cancel_reg <= cancel_next;
            timer_reg  <= timer_next;
            delay_reg  <= delay_next;
        end
    end

    always_comb
    begin
        action_next = ACT_NONE;
        cancel_next = 1'b0;
        timer_next  = 1'b0;
        delay_next  = '0;
        paused_next = paused_reg;
        boost_next  = boost_reg;
        priority if ((func_reg == FUNC_SAMPLE) && enable_reg)
        begin
            priority if (avg >= ALL_THR && hi > cores_reg)
            begin
                paused_next = 1'b1;
                cancel_next = pending_reg;
                action_next = ACT_ALL;
            end
            else if (paused_reg)
            begin
                action_next = ACT_RESAMPLE;
                delay_next  = DELAY_W'(eff_ivl);
            end
            else if (avg >= AVG_W'(raise_prod_reg) && hi > cores_reg)
            begin
                cancel_next = pending_reg;
                action_next = ACT_ONE;
            end
            else
            begin
                if (avg <= AVG_W'(lower_prod_reg) && lo < cores_reg)
                begin
                    if (!pending_reg)
                    begin
                        action_next = ACT_OFF;
                    end
                    boost_next = 1'b0;
                end
                delay_next = dly_sat;
            end
        end
        else if ((func_reg == FUNC_BOOST) && enable_reg && !susp_reg)
        begin
            if (!boost_reg && hi > cores_reg)
            begin
                boost_next = 1'b1;
                priority if (cores_reg < CORE_W'(2))
                begin
                    cancel_next = 1'b1;
                    paused_next = 1'b1;
                    action_next = ACT_ONE;
                    timer_next  = 1'b1;
                end
                else if (pending_reg)
                begin
                    cancel_next = 1'b1;
                    paused_next = 1'b1;
                    timer_next  = 1'b1;
                    delay_next  = DELAY_W'(eff_ivl);
                end
                else
                begin
                    timer_next  = 1'b0;
                end
            end
        end
        else if (func_reg == FUNC_UNPAUSE)
        begin
            paused_next = 1'b0;
        end
        else
        begin
            action_next = ACT_NONE;
        end
    end

    assign action              = action_reg;
    assign cancel_offline      = cancel_reg;
    assign start_unpause_timer = timer_reg;
    assign next_delay          = delay_reg;
    assign average_load        = avg;
    assign paused_now          = paused_reg;
    assign boost_now           = boost_reg;

endmodule

### rtl/load_average_core_count_governor_top.sv
// Load-based core-count governor. Each event transfer on evt (load sample, boost
// request or unpause expiry) yields exactly one result transfer on res. Events are
// handled one at a time: evt.ready is high only while the block is idle, and a
// result stays on res until taken. A load sample with the governor enabled raises
// res.valid after a ring read, ring update, average and threshold multiplies, delay
// scaling and decision, in that order; other events skip the ring update. A new event
// is accepted only after the previous result has been taken. The averaging divide
// is a reciprocal multiply, so HISTORY_DEPTH need not be a power of two.
// Configuration writes on cfg are always accepted and must be made while idle.
module load_average_core_count_governor_top #(
    parameter int HISTORY_DEPTH = lacg_pkg::DEF_HISTORY_DEPTH,
    parameter int NUM_CORES     = lacg_pkg::DEF_NUM_CORES
) (
    input  logic        clk,
    input  logic        rst_n,
    lacg_in_if.sink     evt,
    lacg_out_if.source  res,
    lacg_cfg_if.sink    cfg
);
    import lacg_pkg::*;

    lacg_cmd_t    cmd;
    lacg_status_t status;

    assign cfg.ready = 1'b1;

    lacg_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .evt_valid (evt.valid),
        .evt_ready (evt.ready),
        .res_valid (res.valid),
        .res_ready (res.ready),
        .status    (status),
        .cmd       (cmd)
    );

    lacg_dp #(
        .HISTORY_DEPTH (HISTORY_DEPTH),
        .NUM_CORES     (NUM_CORES)
    ) u_dp (
        .clk                 (clk),
        .rst_n               (rst_n),
        .cmd                 (cmd),
        .status              (status),
        .func                (evt.func),
        .run_count           (evt.run_count),
        .cores_online        (evt.cores_online),
        .offline_pending     (evt.offline_pending),
        .screen_suspended    (evt.screen_suspended),
        .cfg_write           (cfg.valid && cfg.ready),
        .cfg_index           (cfg.index),
        .cfg_data            (cfg.data),
        .action              (res.action),
        .cancel_offline      (res.cancel_offline),
        .start_unpause_timer (res.start_unpause_timer),
        .next_delay          (res.next_delay),
        .average_load        (res.average_load),
        .paused_now          (res.paused_now),
        .boost_now           (res.boost_now)
    );

endmodule

### rtl/lacg_checker.sv
module lacg_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        evt_valid,
    input logic        evt_ready,
    input logic        res_valid,
    input logic        res_ready,
    input logic [2:0]  res_action,
    input logic [22:0] res_next_delay
);
    import lacg_pkg::*;

    // one event in flight: no acceptance while a result is pending
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(evt_ready && res_valid))
        else $error("evt ready while result pending");

    // a result never appears the cycle right after acceptance
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (evt_valid && evt_ready) |=> !res_valid)
        else $error("result too early");

    a_action_code: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> (res_action == ACT_NONE || res_action == ACT_ALL ||
                       res_action == ACT_ONE || res_action == ACT_OFF ||
                       res_action == ACT_RESAMPLE))
        else $error("bad action code");

    // online decisions schedule no sample
    a_online_no_delay: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && (res_action == ACT_ALL || res_action == ACT_ONE))
            |-> (res_next_delay == '0))
        else $error("online action with delay");

    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && !res_ready) |=> res_valid)
        else $error("result dropped before transfer");

endmodule

bind load_average_core_count_governor_top lacg_checker u_lacg_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .evt_valid      (evt.valid),
    .evt_ready      (evt.ready),
    .res_valid      (res.valid),
    .res_ready      (res.ready),
    .res_action     (res.action),
    .res_next_delay (res.next_delay)
);

### verif/tb.sv
`timescale 1ns / 1ps

module tb;
    import lacg_pkg::*;

    localparam int HIST_DEPTH = DEF_HISTORY_DEPTH;
    localparam int N_CORES    = DEF_NUM_CORES;
    localparam int CYCLE_LIMIT = 400000;
    localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;

    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic [RUN_W-1:0]  run;
        logic [CORE_W-1:0] cores;
        logic              pend;
        logic              susp;
    } gov_event_t;

    typedef struct packed {
        logic [ACTION_W-1:0] action;
        logic                cancel;
        logic                timer;
        logic [DELAY_W-1:0]  delay;
        logic [AVG_W-1:0]    avg;
        logic                paused;
        logic                boost;
    } gov_result_t;

    logic clk;
    logic rst_n;

    lacg_in_if  evt_if();
    lacg_out_if res_if();
    lacg_cfg_if cfg_if();

    load_average_core_count_governor_top #(
        .HISTORY_DEPTH(HIST_DEPTH),
        .NUM_CORES(N_CORES)
    ) u_dut (
        .clk(clk),
        .rst_n(rst_n),
        .evt(evt_if),
        .res(res_if),
        .cfg(cfg_if)
    );

    // governor state mirror
    int unsigned hist_loads [HIST_DEPTH] = '{default: 0};
    int unsigned hist_idx = 0;
    int unsigned hist_sum = 0;
    logic gov_paused = 1'b1;
    logic gov_boost  = 1'b0;

    logic              cfg_enable   = 1'b0;
    logic [CORE_W-1:0] cfg_min      = 4'd2;
    logic [CORE_W-1:0] cfg_max      = 4'd4;
    logic [IVL_W-1:0]  cfg_interval = 16'd20;
    logic [SCALE_W-1:0] cfg_scale   = 4'd2;
    logic [THR_W-1:0]  cfg_raise    = 10'd200;
    logic [THR_W-1:0]  cfg_lower    = 10'd50;

    gov_result_t results_due [$];
    gov_result_t got_want;

    int mismatches = 0;
    int sent_count = 0;
    int checked_count = 0;
    int cfg_writes = 0;
    int cycles = 0;
    int idle_pct = 0;
    int stall_pct = 0;

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("load_average_core_count_governor_top: mismatch");
            $finish;
        end
    end

    always @(negedge clk) begin
        res_if.ready = ($urandom_range(99) >= stall_pct);
    end

    function automatic int unsigned eff_interval();
        return (cfg_interval == 0) ? DEFAULT_INTERVAL : cfg_interval;
    endfunction

    function automatic logic [DELAY_W-1:0] scaled_delay(int unsigned cores);
        longint unsigned d;
        d = longint'(eff_interval()) * cores;
        d = d * ((cfg_scale == 0) ? cores : cfg_scale);
        return (d > DELAY_MAX) ? DELAY_MAX : d[DELAY_W-1:0];
    endfunction

    function automatic gov_result_t governor_step(gov_event_t ev);
        gov_result_t r;
        int unsigned cores;
        int unsigned lo;
        int unsigned hi;
        int unsigned avg;
        int unsigned sample;
        r = '0;
        cores = (ev.cores == 0) ? 1 : ev.cores;
        lo = (cfg_min == 0) ? 1 : cfg_min;
        hi = (cfg_max > N_CORES) ? N_CORES : cfg_max;
        if (ev.func == FUNC_SAMPLE && cfg_enable) begin
            sample = ev.run * LOAD_UNIT;
            hist_sum = hist_sum - hist_loads[hist_idx] + sample;
            hist_loads[hist_idx] = sample;
            hist_idx = (hist_idx == HIST_DEPTH - 1) ? 0 : hist_idx + 1;
            avg = hist_sum / HIST_DEPTH;
            if (avg >= ALL_LOAD_PER_CORE * N_CORES && hi > cores) begin
                gov_paused = 1'b1;
                r.cancel = ev.pend;
                r.action = ACT_ALL;
            end else if (gov_paused) begin
                r.action = ACT_RESAMPLE;
                r.delay = DELAY_W'(eff_interval());
            end else if (avg >= cfg_raise * cores && hi > cores) begin
                r.cancel = ev.pend;
                r.action = ACT_ONE;
            end else begin
                if (avg <= cfg_lower * cores && lo < cores) begin
                    if (!ev.pend)
                        r.action = ACT_OFF;
                    gov_boost = 1'b0;
                end
                r.delay = scaled_delay(cores);
            end
        end else if (ev.func == FUNC_BOOST && cfg_enable && !ev.susp) begin
            if (!gov_boost && hi > cores) begin
                gov_boost = 1'b1;
                if (cores < 2) begin
                    r.cancel = 1'b1;
                    gov_paused = 1'b1;
                    r.action = ACT_ONE;
                    r.timer = 1'b1;
                end else if (ev.pend) begin
                    r.cancel = 1'b1;
                    gov_paused = 1'b1;
                    r.timer = 1'b1;
                    r.delay = DELAY_W'(eff_interval());
                end
            end
        end else if (ev.func == FUNC_UNPAUSE) begin
            gov_paused = 1'b0;
        end
        r.avg = AVG_W'(hist_sum / HIST_DEPTH);
        r.paused = gov_paused;
        r.boost = gov_boost;
        return r;
    endfunction

    function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endfunction

    always @(posedge clk) begin
        if (rst_n && res_if.valid && res_if.ready) begin
            if (results_due.size() == 0) begin
                $error("result transfer with nothing outstanding");
                mismatches++;
            end else begin
                got_want = results_due.pop_front();
                check_field("action", got_want.action, res_if.action);
                check_field("cancel_offline", got_want.cancel, res_if.cancel_offline);
                check_field("start_unpause_timer", got_want.timer, res_if.start_unpause_timer);
                check_field("next_delay", got_want.delay, res_if.next_delay);
                check_field("average_load", got_want.avg, res_if.average_load);
                check_field("paused_now", got_want.paused, res_if.paused_now);
                check_field("boost_now", got_want.boost, res_if.boost_now);
                checked_count++;
            end
        end
    end

    function automatic gov_event_t mk(logic [FUNC_W-1:0] f, int run, int cores,
                                      bit pend, bit susp);
        gov_event_t ev;
        ev.func = f;
        ev.run = RUN_W'(run);
        ev.cores = CORE_W'(cores);
        ev.pend = pend;
        ev.susp = susp;
        return ev;
    endfunction

    task automatic send_event(gov_event_t ev);
        @(negedge clk);
        if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
            evt_if.valid = 1'b0;
            do
                @(negedge clk);
            while ($urandom_range(99) < idle_pct);
        end
        evt_if.func = ev.func;
        evt_if.run_count = ev.run;
        evt_if.cores_online = ev.cores;
        evt_if.offline_pending = ev.pend;
        evt_if.screen_suspended = ev.susp;
        evt_if.valid = 1'b1;
        do
            @(posedge clk);
        while (!evt_if.ready);
        results_due.push_back(governor_step(ev));
        sent_count++;
    endtask

    task automatic wait_idle();
        @(negedge clk);
        evt_if.valid = 1'b0;
        while (results_due.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
    endtask

    task automatic write_reg(cfg_reg_t idx, int unsigned val);
        @(negedge clk);
        cfg_if.index = idx;
        cfg_if.data = CFG_DATA_W'(val);
        cfg_if.valid = 1'b1;
        do
            @(posedge clk);
        while (!cfg_if.ready);
        case (idx)
            REG_ENABLE:    cfg_enable = val[0];
            REG_MIN_CORES: cfg_min = val[CORE_W-1:0];
            REG_MAX_CORES: cfg_max = val[CORE_W-1:0];
            REG_INTERVAL:  cfg_interval = val[IVL_W-1:0];
            REG_SCALE:     cfg_scale = val[SCALE_W-1:0];
            REG_RAISE:     cfg_raise = val[THR_W-1:0];
            REG_LOWER:     cfg_lower = val[THR_W-1:0];
            default: ;
        endcase
        cfg_writes++;
        @(negedge clk);
        cfg_if.valid = 1'b0;
    endtask

    function automatic int pick_core_limit();
        return ($urandom_range(3) == 0) ? $urandom_range(0, 15) : $urandom_range(1, 8);
    endfunction

    function automatic gov_event_t random_event();
        gov_event_t ev;
        int sel;
        sel = $urandom_range(99);
        ev.func = (sel < 70) ? FUNC_SAMPLE : (sel < 82) ? FUNC_BOOST :
                  (sel < 95) ? FUNC_UNPAUSE : FUNC_UNUSED;
        sel = $urandom_range(9);
        ev.run = RUN_W'((sel < 5) ? $urandom_range(0, 20) :
                        (sel < 8) ? $urandom_range(0, 200) : $urandom_range(0, 1023));
        ev.cores = CORE_W'(($urandom_range(9) == 0) ? $urandom_range(0, 15) :
                           $urandom_range(1, 8));
        ev.pend = 1'($urandom_range(1));
        ev.susp = ($urandom_range(3) == 0);
        return ev;
    endfunction

    // reset state: governor off, only unpause has an effect
    task automatic test_disabled_after_reset();
        send_event(mk(FUNC_SAMPLE, 1023, 8, 1, 1));
        send_event(mk(FUNC_BOOST, 0, 1, 0, 0));
        send_event(mk(FUNC_UNUSED, 1023, 8, 1, 1));
        send_event(mk(FUNC_UNPAUSE, 0, 1, 0, 0));
        wait_idle();
    endtask

    task automatic test_directed_cases();
        write_reg(REG_ENABLE, 1);
        write_reg(REG_RAISE, 10);
        write_reg(REG_LOWER, 0);
        send_event(mk(FUNC_SAMPLE, 4, 0, 1, 0));
        send_event(mk(FUNC_SAMPLE, 1, 4, 0, 0));
        send_event(mk(FUNC_BOOST, 0, 1, 0, 0));
        send_event(mk(FUNC_BOOST, 0, 1, 0, 0));
        send_event(mk(FUNC_SAMPLE, 0, 3, 0, 0));
        send_event(mk(FUNC_UNPAUSE, 0, 3, 0, 0));
        send_event(mk(FUNC_SAMPLE, 1023, 3, 1, 1));
        wait_idle();

        write_reg(REG_RAISE, 1023);
        write_reg(REG_LOWER, 1023);
        write_reg(REG_MIN_CORES, 0);
        write_reg(REG_MAX_CORES, 15);
        send_event(mk(FUNC_UNPAUSE, 1023, 15, 1, 1));
        send_event(mk(FUNC_SAMPLE, 0, 15, 0, 0));
        send_event(mk(FUNC_SAMPLE, 0, 15, 1, 0));
        send_event(mk(FUNC_BOOST, 0, 2, 1, 0));
        send_event(mk(FUNC_BOOST, 0, 2, 1, 1));
        wait_idle();

        write_reg(REG_INTERVAL, 0);
        write_reg(REG_SCALE, 0);
        send_event(mk(FUNC_UNPAUSE, 0, 4, 0, 0));
        send_event(mk(FUNC_SAMPLE, 0, 4, 0, 0));
        send_event(mk(FUNC_SAMPLE, 0, 0, 0, 0));
        wait_idle();

        write_reg(REG_INTERVAL, 16'hFFFF);
        write_reg(REG_SCALE, 15);
        write_reg(REG_MAX_CORES, 8);
        send_event(mk(FUNC_SAMPLE, 0, 15, 1, 0));
        send_event(mk(FUNC_SAMPLE, 0, 4, 0, 0));
        wait_idle();

        write_reg(REG_ENABLE, 0);
        send_event(mk(FUNC_SAMPLE, 1023, 1, 0, 0));
        send_event(mk(FUNC_BOOST, 0, 1, 1, 0));
        wait_idle();
    endtask

    task automatic test_random_traffic();
        int idle_tab [4] = '{0, 66, 0, 8};
        int stall_tab [4] = '{0, 0, 66, 8};
        int sel;
        for (int ph = 0; ph < 4; ph++) begin
            idle_pct = idle_tab[ph];
            stall_pct = stall_tab[ph];
            for (int s = 0; s < 2; s++) begin
                wait_idle();
                write_reg(REG_ENABLE, $urandom_range(7) != 0);
                write_reg(REG_MIN_CORES, pick_core_limit());
                write_reg(REG_MAX_CORES, pick_core_limit());
                sel = $urandom_range(4);
                write_reg(REG_INTERVAL, (sel == 0) ? 0 : (sel == 1) ? 16'hFFFF :
                          (sel == 2) ? $urandom_range(1, 65535) : $urandom_range(1, 200));
                write_reg(REG_SCALE, $urandom_range(15));
                write_reg(REG_RAISE, ($urandom_range(4) == 0) ? $urandom_range(1023) :
                          $urandom_range(0, 300));
                write_reg(REG_LOWER, ($urandom_range(4) == 0) ? $urandom_range(1023) :
                          $urandom_range(0, 120));
                repeat (75) send_event(random_event());
            end
        end
        idle_pct = 0;
        stall_pct = 0;
    endtask

    initial begin
        rst_n = 1'b0;
        evt_if.valid = 1'b0;
        evt_if.func = FUNC_SAMPLE;
        evt_if.run_count = '0;
        evt_if.cores_online = '0;
        evt_if.offline_pending = 1'b0;
        evt_if.screen_suspended = 1'b0;
        cfg_if.valid = 1'b0;
        cfg_if.index = REG_ENABLE;
        cfg_if.data = '0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_disabled_after_reset();
        test_directed_cases();
        test_random_traffic();
        wait_idle();

        $display("Sent %0d events (samples, boosts, unpause expiries, unused code), %0d results checked.",
                 sent_count, checked_count);
        $display("Register writes: %0d, over directed extremes and 8 random settings in 4 pacing modes.",
                 cfg_writes);
        if (mismatches == 0)
            $display("load_average_core_count_governor_top: match");
        else
            $display("load_average_core_count_governor_top: mismatch");
        $finish;
    end

endmodule
